@@ rtl/rlzdd_pkg.sv @@
// Shared types and constants of the dictionary/run-length/back-reference decompressor.
package rlzdd_pkg;

   // History memory: one byte per output position
   localparam int HistDepth = 65536;
   localparam int HistAw = $clog2(HistDepth);

   // Word table kept as bytes, low byte at even address
   localparam int TableBytes = 128;
   localparam int TableAw = $clog2(TableBytes);

   // Output position, copy address and limit width
   localparam int PosW = 17;

   // Control byte layout
   localparam int CountW = 6;
   localparam logic [7:0] CountMask = 8'h3F;

   // Configuration port
   localparam int CsrAw = 3;
   localparam int CsrDw = 32;
   localparam logic [0:0] RegOutputLimit = 1'b0;
   localparam logic [PosW-1:0] LimitReset = 17'h10000;

   // Stream widths
   localparam int ReqDw = 8;
   localparam int RspDw = 16;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_TRUNC = 2'd1,
      ERR_HIST  = 2'd2,
      ERR_LIMIT = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      MODE_LITERAL = 2'd0,
      MODE_RUN     = 2'd1,
      MODE_COPY    = 2'd2,
      MODE_WORD    = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_HEADER,
      ST_CONTROL,
      ST_LITERAL,
      ST_RUNVAL,
      ST_ADDRLO,
      ST_ADDRHI,
      ST_RUN,
      ST_COPY_RD,
      ST_COPY_EMIT,
      ST_WORD_LO,
      ST_WORD_HI,
      ST_STATUS,
      ST_DONE
   } state_type;

   // One result headed for the output register
   typedef struct packed {
      logic    en;
      logic [7:0] data;
      logic    vld;
      logic    last;
      logic    done;
      err_type code;
   } emit_type;

endpackage

@@ rtl/rlzdd_out_stage.sv @@
// Output register of the result stream, parting the sequencer from the consumer.
module rlzdd_out_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  rlzdd_pkg::emit_type            emit,
   output logic                           free,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_byte, [8] stream_done, [10:9] error_code, [15:11] zero
   output logic [rlzdd_pkg::RspDw-1:0]    rsp_tdata,
   // [0] out_valid
   output logic                           rsp_tuser,
   output logic                           rsp_tlast
);

   logic                valid_ff;
   logic                valid_in;
   rlzdd_pkg::emit_type res_ff;

   // Slot is free when empty or being drained this cycle
   assign free = !valid_ff || rsp_tready;
   assign valid_in = free ? emit.en : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new item only into a free slot
   always_ff @(posedge clock) begin
      if (free && emit.en) begin
         res_ff <= emit;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {5'd0, res_ff.code, res_ff.done, res_ff.data};
   assign rsp_tuser = res_ff.vld;
   assign rsp_tlast = res_ff.last;

endmodule

@@ rtl/rle_lz_dictionary_decompressor_unit.sv @@
// Top level: byte-serial decompressor with word table, run, literal and history copy.
//
//   channel | ports        | dir | payload
//   --------+--------------+-----+----------------------------------------------
//   request | req_t*       | in  | tdata: in_byte; tlast: in_last
//   result  | rsp_t*       | out | tdata: out_byte, stream_done, error_code;
//           |              |     | tuser: out_valid; tlast: run_last
//   control | csr_p*       | in  | register 0 at byte 0: output_limit (17 bits)
//
// A run takes its value byte and then emits; a copy takes two address bytes, primes a
// history read and then emits; a table word emits its low byte, then its high byte.
// Emission, if unstalled, is one byte per cycle, set by the single write port of the
// history memory, which feeds copies back through a one-entry forward register.
// Reset is synchronous and clears control state; table and history are not cleared.
// A stalled result channel freezes all but the copy read and holds off request items.
module rle_lz_dictionary_decompressor_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [7:0] in_byte
   input  logic [rlzdd_pkg::ReqDw-1:0]    req_tdata,
   input  logic                           req_tlast,
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_byte, [8] stream_done, [10:9] error_code, [15:11] zero
   output logic [rlzdd_pkg::RspDw-1:0]    rsp_tdata,
   // [0] out_valid
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rlzdd_pkg::CsrAw-1:0]    csr_paddr,
   input  logic [rlzdd_pkg::CsrDw-1:0]    csr_pwdata,
   output logic [rlzdd_pkg::CsrDw-1:0]    csr_prdata,
   output logic                           csr_pready
);

   localparam int HistAw = rlzdd_pkg::HistAw;
   localparam int TableAw = rlzdd_pkg::TableAw;
   localparam int PosW = rlzdd_pkg::PosW;
   localparam int CountW = rlzdd_pkg::CountW;
   localparam logic [PosW-1:0] HistSpan = PosW'(rlzdd_pkg::HistDepth);
   localparam logic [TableAw-1:0] HdrLast = TableAw'(rlzdd_pkg::TableBytes - 1);

   // Control and pointer registers
   rlzdd_pkg::state_type state_ff, state_in;
   logic [TableAw-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [CountW-1:0]    rem_ff, rem_in;
   logic [PosW-1:0]      ca_ff, ca_in;
   logic [PosW-1:0]      pos_ff, pos_in;
   logic [7:0]           run_byte_ff, run_byte_in;
   logic                 last_ff, last_in;
   rlzdd_pkg::err_type   end_code_ff, end_code_in;
   logic [PosW-1:0]      limit_ff, limit_in;

   // Memories and their ports
   logic [7:0]           tbl_mem [rlzdd_pkg::TableBytes];
   logic [7:0]           tbl_rdata_ff;
   logic                 tbl_we, tbl_re;
   logic [TableAw-1:0]   tbl_raddr;
   logic [7:0]           hist_mem [rlzdd_pkg::HistDepth];
   logic [7:0]           hist_rdata_ff;
   logic                 hist_we, hist_re;
   logic [HistAw-1:0]    hist_waddr, hist_raddr;
   logic [7:0]           hist_wdata;
   logic                 fwd_hit_ff;
   logic [7:0]           fwd_data_ff;

   // Datapath helpers
   rlzdd_pkg::emit_type  emit;
   logic                 out_free;
   logic                 accept;
   logic [7:0]           in_byte;
   logic                 limit_hit;
   logic                 hist_bad;
   logic [7:0]           copy_data;
   logic [CountW-1:0]    rem_dec;
   logic [PosW-1:0]      pos_inc;
   logic [PosW-1:0]      ca_inc;
   logic                 csr_wr;
   logic                 csr_sel_limit;

   function automatic rlzdd_pkg::emit_type byte_res(logic [7:0] data, logic last,
                                                    logic done);
      rlzdd_pkg::emit_type r;
      r.en = 1'b1;
      r.data = data;
      r.vld = 1'b1;
      r.last = last;
      r.done = done;
      r.code = rlzdd_pkg::ERR_NONE;
      return r;
   endfunction

   function automatic rlzdd_pkg::emit_type status_res(rlzdd_pkg::err_type code);
      rlzdd_pkg::emit_type r;
      r.en = 1'b1;
      r.data = 8'd0;
      r.vld = 1'b0;
      r.last = 1'b1;
      r.done = 1'b1;
      r.code = code;
      return r;
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_sel_limit = (csr_paddr[rlzdd_pkg::CsrAw-1:2] == rlzdd_pkg::RegOutputLimit);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_sel_limit;
   assign limit_in = csr_wr ? csr_pwdata[PosW-1:0] : limit_ff;
   assign csr_prdata = csr_sel_limit ? rlzdd_pkg::CsrDw'(limit_ff) : '0;

   // Shared conditions
   assign in_byte = req_tdata;
   assign accept = req_tvalid && req_tready;
   assign limit_hit = (pos_ff >= limit_ff) || pos_ff[PosW-1];
   assign hist_bad = (ca_ff >= pos_ff) || ((pos_ff - ca_ff) > HistSpan);
   assign copy_data = fwd_hit_ff ? fwd_data_ff : hist_rdata_ff;
   assign rem_dec = rem_ff - CountW'(1);
   assign pos_inc = pos_ff + PosW'(1);
   assign ca_inc = ca_ff + PosW'(1);
   assign hist_waddr = pos_ff[HistAw-1:0];

   // Take request items only in the byte-consuming states with room downstream
   always_comb begin
      req_tready = 1'b0;
      if (out_free) begin
         if (state_ff inside {rlzdd_pkg::ST_HEADER, rlzdd_pkg::ST_CONTROL,
                              rlzdd_pkg::ST_LITERAL, rlzdd_pkg::ST_RUNVAL,
                              rlzdd_pkg::ST_ADDRLO, rlzdd_pkg::ST_ADDRHI,
                              rlzdd_pkg::ST_DONE}) begin
            req_tready = 1'b1;
         end
      end
   end

   // Sequencer: next state, memory accesses and emitted result
   always_comb begin
      state_in = state_ff;
      hdr_idx_in = hdr_idx_ff;
      rem_in = rem_ff;
      ca_in = ca_ff;
      pos_in = pos_ff;
      run_byte_in = run_byte_ff;
      last_in = last_ff;
      end_code_in = end_code_ff;
      emit = '0;
      tbl_we = 1'b0;
      tbl_re = 1'b0;
      tbl_raddr = '0;
      hist_we = 1'b0;
      hist_re = 1'b0;
      hist_raddr = '0;
      hist_wdata = '0;

      case (state_ff)
         rlzdd_pkg::ST_HEADER: begin
            if (accept) begin
               tbl_we = 1'b1;
               if (hdr_idx_ff == HdrLast) begin
                  state_in = rlzdd_pkg::ST_CONTROL;
               end else begin
                  hdr_idx_in = hdr_idx_ff + TableAw'(1);
               end
               if (req_tlast) begin
                  emit = status_res(rlzdd_pkg::ERR_NONE);
                  end_code_in = rlzdd_pkg::ERR_NONE;
                  state_in = rlzdd_pkg::ST_DONE;
               end
            end
         end

         rlzdd_pkg::ST_CONTROL: begin
            if (accept) begin
               if (in_byte == 8'd0) begin
                  // End marker
                  emit = status_res(rlzdd_pkg::ERR_NONE);
                  end_code_in = rlzdd_pkg::ERR_NONE;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  rem_in = in_byte[CountW-1:0];
                  last_in = req_tlast;
                  case (rlzdd_pkg::mode_type'(in_byte[7:6]))
                     rlzdd_pkg::MODE_LITERAL: state_in = rlzdd_pkg::ST_LITERAL;
                     rlzdd_pkg::MODE_RUN:     state_in = rlzdd_pkg::ST_RUNVAL;
                     rlzdd_pkg::MODE_COPY:    state_in = rlzdd_pkg::ST_ADDRLO;
                     default: begin
                        // Table word: fetch the low byte
                        tbl_re = 1'b1;
                        tbl_raddr = {in_byte[CountW-1:0], 1'b0};
                        state_in = rlzdd_pkg::ST_WORD_LO;
                     end
                  endcase
                  if (req_tlast && in_byte[7:6] != rlzdd_pkg::MODE_WORD) begin
                     emit = status_res(rlzdd_pkg::ERR_TRUNC);
                     end_code_in = rlzdd_pkg::ERR_TRUNC;
                     state_in = rlzdd_pkg::ST_DONE;
                  end
               end
            end
         end

         rlzdd_pkg::ST_LITERAL: begin
            if (accept) begin
               if (limit_hit) begin
                  emit = status_res(rlzdd_pkg::ERR_LIMIT);
                  end_code_in = rlzdd_pkg::ERR_LIMIT;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  hist_we = 1'b1;
                  hist_wdata = in_byte;
                  pos_in = pos_inc;
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     emit = byte_res(in_byte, 1'b1, req_tlast);
                     if (req_tlast) begin
                        end_code_in = rlzdd_pkg::ERR_NONE;
                        state_in = rlzdd_pkg::ST_DONE;
                     end else begin
                        state_in = rlzdd_pkg::ST_CONTROL;
                     end
                  end else if (req_tlast) begin
                     // Truncated: the status item follows
                     emit = byte_res(in_byte, 1'b0, 1'b0);
                     end_code_in = rlzdd_pkg::ERR_TRUNC;
                     state_in = rlzdd_pkg::ST_STATUS;
                  end else begin
                     emit = byte_res(in_byte, 1'b1, 1'b0);
                  end
               end
            end
         end

         rlzdd_pkg::ST_RUNVAL: begin
            if (accept) begin
               run_byte_in = in_byte;
               last_in = req_tlast;
               if (rem_ff != '0) begin
                  state_in = rlzdd_pkg::ST_RUN;
               end else if (req_tlast) begin
                  emit = status_res(rlzdd_pkg::ERR_NONE);
                  end_code_in = rlzdd_pkg::ERR_NONE;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  state_in = rlzdd_pkg::ST_CONTROL;
               end
            end
         end

         rlzdd_pkg::ST_RUN: begin
            if (out_free) begin
               if (limit_hit) begin
                  emit = status_res(rlzdd_pkg::ERR_LIMIT);
                  end_code_in = rlzdd_pkg::ERR_LIMIT;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  hist_we = 1'b1;
                  hist_wdata = run_byte_ff;
                  pos_in = pos_inc;
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     emit = byte_res(run_byte_ff, 1'b1, last_ff);
                     end_code_in = rlzdd_pkg::ERR_NONE;
                     state_in = last_ff ? rlzdd_pkg::ST_DONE : rlzdd_pkg::ST_CONTROL;
                  end else begin
                     emit = byte_res(run_byte_ff, 1'b0, 1'b0);
                  end
               end
            end
         end

         rlzdd_pkg::ST_ADDRLO: begin
            if (accept) begin
               ca_in = PosW'(in_byte);
               if (req_tlast) begin
                  emit = status_res(rlzdd_pkg::ERR_TRUNC);
                  end_code_in = rlzdd_pkg::ERR_TRUNC;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  state_in = rlzdd_pkg::ST_ADDRHI;
               end
            end
         end

         rlzdd_pkg::ST_ADDRHI: begin
            if (accept) begin
               ca_in = {1'b0, in_byte, ca_ff[7:0]};
               last_in = req_tlast;
               if (rem_ff != '0) begin
                  state_in = rlzdd_pkg::ST_COPY_RD;
               end else if (req_tlast) begin
                  emit = status_res(rlzdd_pkg::ERR_NONE);
                  end_code_in = rlzdd_pkg::ERR_NONE;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  state_in = rlzdd_pkg::ST_CONTROL;
               end
            end
         end

         rlzdd_pkg::ST_COPY_RD: begin
            // Prime the history read
            hist_re = 1'b1;
            hist_raddr = ca_ff[HistAw-1:0];
            state_in = rlzdd_pkg::ST_COPY_EMIT;
         end

         rlzdd_pkg::ST_COPY_EMIT: begin
            if (out_free) begin
               if (hist_bad) begin
                  emit = status_res(rlzdd_pkg::ERR_HIST);
                  end_code_in = rlzdd_pkg::ERR_HIST;
                  state_in = rlzdd_pkg::ST_DONE;
               end else if (limit_hit) begin
                  emit = status_res(rlzdd_pkg::ERR_LIMIT);
                  end_code_in = rlzdd_pkg::ERR_LIMIT;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  hist_we = 1'b1;
                  hist_wdata = copy_data;
                  pos_in = pos_inc;
                  ca_in = ca_inc;
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     emit = byte_res(copy_data, 1'b1, last_ff);
                     end_code_in = rlzdd_pkg::ERR_NONE;
                     state_in = last_ff ? rlzdd_pkg::ST_DONE : rlzdd_pkg::ST_CONTROL;
                  end else begin
                     // Read the next source byte while this one is written back
                     emit = byte_res(copy_data, 1'b0, 1'b0);
                     hist_re = 1'b1;
                     hist_raddr = ca_inc[HistAw-1:0];
                  end
               end
            end
         end

         rlzdd_pkg::ST_WORD_LO: begin
            if (out_free) begin
               if (limit_hit) begin
                  emit = status_res(rlzdd_pkg::ERR_LIMIT);
                  end_code_in = rlzdd_pkg::ERR_LIMIT;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  emit = byte_res(tbl_rdata_ff, 1'b0, 1'b0);
                  hist_we = 1'b1;
                  hist_wdata = tbl_rdata_ff;
                  pos_in = pos_inc;
                  tbl_re = 1'b1;
                  tbl_raddr = {rem_ff, 1'b1};
                  state_in = rlzdd_pkg::ST_WORD_HI;
               end
            end
         end

         rlzdd_pkg::ST_WORD_HI: begin
            if (out_free) begin
               if (limit_hit) begin
                  emit = status_res(rlzdd_pkg::ERR_LIMIT);
                  end_code_in = rlzdd_pkg::ERR_LIMIT;
                  state_in = rlzdd_pkg::ST_DONE;
               end else begin
                  emit = byte_res(tbl_rdata_ff, 1'b1, last_ff);
                  hist_we = 1'b1;
                  hist_wdata = tbl_rdata_ff;
                  pos_in = pos_inc;
                  end_code_in = rlzdd_pkg::ERR_NONE;
                  state_in = last_ff ? rlzdd_pkg::ST_DONE : rlzdd_pkg::ST_CONTROL;
               end
            end
         end

         rlzdd_pkg::ST_STATUS: begin
            if (out_free) begin
               emit = status_res(end_code_ff);
               state_in = rlzdd_pkg::ST_DONE;
            end
         end

         rlzdd_pkg::ST_DONE: begin
            if (accept) begin
               emit = status_res(end_code_ff);
            end
         end

         default: begin
            state_in = rlzdd_pkg::ST_DONE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlzdd_pkg::ST_HEADER;
         hdr_idx_ff <= '0;
         rem_ff <= '0;
         ca_ff <= '0;
         pos_ff <= '0;
         last_ff <= 1'b0;
         end_code_ff <= rlzdd_pkg::ERR_NONE;
         limit_ff <= rlzdd_pkg::LimitReset;
      end else begin
         state_ff <= state_in;
         hdr_idx_ff <= hdr_idx_in;
         rem_ff <= rem_in;
         ca_ff <= ca_in;
         pos_ff <= pos_in;
         last_ff <= last_in;
         end_code_ff <= end_code_in;
         limit_ff <= limit_in;
      end
   end

   // Run byte holds payload only
   always_ff @(posedge clock) begin
      run_byte_ff <= run_byte_in;
   end

   // Word table, byte-wide, filled by the header
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[hdr_idx_ff] <= in_byte;
      end
      if (tbl_re) begin
         tbl_rdata_ff <= tbl_mem[tbl_raddr];
      end
   end

   // Output history; flag a read of the entry written in the same cycle
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         hist_rdata_ff <= hist_mem[hist_raddr];
         fwd_hit_ff <= hist_we && (hist_waddr == hist_raddr);
         fwd_data_ff <= hist_wdata;
      end
   end

   rlzdd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/rlzdd_checker.sv @@
// Port-level checks of the decompressor result stream, bound to the top level.
module rlzdd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rlzdd_pkg::RspDw-1:0]    rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);

   logic done_seen_ff;

   // Remember that the end of stream has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[8]) begin
         done_seen_ff <= 1'b1;
      end
   end

   // An error code appears only with the end of stream
   a_err_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:9] != 2'd0) |-> rsp_tdata[8])
      else $error("error code without stream_done");

   // A status item carries a zero byte
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[7:0] == 8'd0))
      else $error("status item with nonzero byte");

   // After the end, only status items with stream_done follow
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && done_seen_ff |-> rsp_tdata[8] && !rsp_tuser)
      else $error("item after end of stream is not a done status");

   // The end of stream closes the items of its input byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tlast)
      else $error("stream_done without run_last");

   // A stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

endmodule

bind rle_lz_dictionary_decompressor_unit rlzdd_checker u_rlzdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
